// ===== sv/aesem_pkg.sv =====
`default_nettype none

package aesem_pkg;

   // longest sequence: reset colours, two five-byte groups
   localparam int unsigned SeqMax = 10;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] len_type;
   typedef logic [2:0] func_type;

   // command codes
   localparam func_type FUNC_CLEAR       = 3'd0;
   localparam func_type FUNC_GOTO        = 3'd1;
   localparam func_type FUNC_FORWARD     = 3'd2;
   localparam func_type FUNC_BACKWARD    = 3'd3;
   localparam func_type FUNC_COLOR       = 3'd4;
   localparam func_type FUNC_RESET_COLOR = 3'd5;

   // ascii characters used in the sequences
   localparam byte_type CHAR_ESC      = 8'h1B;
   localparam byte_type CHAR_LBRACKET = 8'h5B;
   localparam byte_type CHAR_SEMI     = 8'h3B;
   localparam byte_type CHAR_UPPER_H  = 8'h48;
   localparam byte_type CHAR_UPPER_C  = 8'h43;
   localparam byte_type CHAR_UPPER_D  = 8'h44;
   localparam byte_type CHAR_UPPER_J  = 8'h4A;
   localparam byte_type CHAR_LOWER_M  = 8'h6D;
   localparam byte_type CHAR_ZERO     = 8'h30;
   localparam byte_type CHAR_TWO      = 8'h32;
   localparam byte_type CHAR_THREE    = 8'h33;
   localparam byte_type CHAR_FOUR     = 8'h34;
   localparam byte_type CHAR_NINE     = 8'h39;

   // byte string under construction, byte 0 goes out first
   typedef struct packed {
      byte_type [SeqMax-1:0] text;
      len_type               len;
   } seq_type;

   // decimal rendering of one 8-bit number, up to three digits
   typedef struct packed {
      byte_type [2:0] text;
      logic [1:0]     len;
   } num_type;

   // decimal digits with no leading zeros, zero as a single digit
   function automatic num_type to_decimal(input byte_type val);
      logic [1:0]  hund;
      logic [6:0]  rest;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [3:0]  ones;
      num_type     res;
      // hundreds by comparison, remainder below one hundred
      if (val >= 8'd200) begin
         hund = 2'd2;
         rest = 7'(val - 8'd200);
      end else if (val >= 8'd100) begin
         hund = 2'd1;
         rest = 7'(val - 8'd100);
      end else begin
         hund = 2'd0;
         rest = val[6:0];
      end
      // tens by reciprocal multiply, exact for values below one hundred
      prod     = 15'(rest) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'(tens) * 7'd10;
      ones     = 4'(rest - tens_x10);
      res.text = {3{CHAR_ZERO}};
      if (hund != 2'd0) begin
         res.text[0] = CHAR_ZERO + byte_type'(hund);
         res.text[1] = CHAR_ZERO + byte_type'(tens);
         res.text[2] = CHAR_ZERO + byte_type'(ones);
         res.len     = 2'd3;
      end else if (tens != 4'd0) begin
         res.text[0] = CHAR_ZERO + byte_type'(tens);
         res.text[1] = CHAR_ZERO + byte_type'(ones);
         res.len     = 2'd2;
      end else begin
         res.text[0] = CHAR_ZERO + byte_type'(ones);
         res.len     = 2'd1;
      end
      return res;
   endfunction

   // append up to three bytes at the current end of the string
   function automatic seq_type append_str(input seq_type s, input byte_type [2:0] str,
                                          input logic [1:0] slen);
      seq_type res;
      len_type pos;
      len_type offs;
      res = s;
      for (int i = 0; i < SeqMax; i++) begin
         pos  = len_type'(i);
         offs = pos - s.len;
         if (pos >= s.len && offs < len_type'(slen)) begin
            res.text[i] = str[offs[1:0]];
         end
      end
      res.len = s.len + len_type'(slen);
      return res;
   endfunction

   function automatic seq_type append_byte(input seq_type s, input byte_type b);
      return append_str(s, {byte_type'(0), byte_type'(0), b}, 2'd1);
   endfunction

   function automatic seq_type append_num(input seq_type s, input byte_type val);
      num_type num;
      num = to_decimal(val);
      return append_str(s, num.text, num.len);
   endfunction

endpackage

`default_nettype wire

// ===== sv/aesem_if.sv =====
`default_nettype none

// command channel
interface aesem_req_if import aesem_pkg::*; ();
   logic     valid;
   logic     ready;
   func_type func;
   byte_type horizontal_amount;
   byte_type row_number;
   byte_type color_code;

   modport source (output valid, func, horizontal_amount, row_number, color_code,
                   input ready);
   modport sink   (input valid, func, horizontal_amount, row_number, color_code,
                   output ready);
   modport monitor (input valid, ready, func, horizontal_amount, row_number, color_code);
endinterface

// byte stream channel
interface aesem_rsp_if import aesem_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type tx_byte;
   logic     last_byte;

   modport source  (output valid, tx_byte, last_byte, input ready);
   modport sink    (input valid, tx_byte, last_byte, output ready);
   modport monitor (input valid, ready, tx_byte, last_byte);
endinterface

`default_nettype wire

// ===== sv/ansi_escape_sequence_emitter_unit.sv =====
// channel   | direction | payload
// ----------+-----------+-------------------------------------------------
// req_bus   | in        | func, horizontal_amount, row_number, color_code
// rsp_bus   | out       | tx_byte, last_byte (set on the final byte)
//
// a command waits in the input register until the output shift register is
// free, then its whole string is built and loaded into it in one pass.
// each command emits 4 to 10 bytes, shifted out of the output shift
// register one byte per accepted beat. unknown commands emit nothing.
// a new command is taken while the previous one is still being sent.
// reset is synchronous and empties both registers; a stall holds the byte.
`default_nettype none

module ansi_escape_sequence_emitter_unit import aesem_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   aesem_req_if.sink   req_bus,
   aesem_rsp_if.source rsp_bus
);

   // input register
   logic     item_valid_ff, item_valid_in;
   func_type func_ff;
   byte_type horiz_ff;
   byte_type row_ff;
   byte_type color_ff;

   // output shift register
   byte_type [SeqMax-1:0] text_ff, text_in;
   len_type               cnt_ff, cnt_in;

   logic    req_beat;
   logic    rsp_beat;
   logic    buf_free;
   logic    load;
   seq_type built;

   // handshakes
   assign req_beat = req_bus.valid && req_bus.ready;
   assign rsp_beat = rsp_bus.valid && rsp_bus.ready;
   assign buf_free = (cnt_ff == len_type'(0)) || (cnt_ff == len_type'(1) && rsp_bus.ready);
   assign load     = item_valid_ff && buf_free;

   assign req_bus.ready     = !item_valid_ff || load;
   assign rsp_bus.valid     = cnt_ff != len_type'(0);
   assign rsp_bus.tx_byte   = text_ff[0];
   assign rsp_bus.last_byte = cnt_ff == len_type'(1);

   // build the escape string of the held command
   always_comb begin
      built.text = '0;
      built.len  = '0;
      unique case (func_ff)
         FUNC_CLEAR: begin
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_byte(built, CHAR_TWO);
            built = append_byte(built, CHAR_UPPER_J);
         end
         FUNC_GOTO: begin
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_num(built, row_ff);
            built = append_byte(built, CHAR_SEMI);
            built = append_num(built, horiz_ff);
            built = append_byte(built, CHAR_UPPER_H);
         end
         FUNC_FORWARD: begin
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_num(built, horiz_ff);
            built = append_byte(built, CHAR_UPPER_C);
         end
         FUNC_BACKWARD: begin
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_num(built, horiz_ff);
            built = append_byte(built, CHAR_UPPER_D);
         end
         FUNC_COLOR: begin
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_num(built, color_ff);
            built = append_byte(built, CHAR_LOWER_M);
         end
         FUNC_RESET_COLOR: begin
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_byte(built, CHAR_THREE);
            built = append_byte(built, CHAR_NINE);
            built = append_byte(built, CHAR_LOWER_M);
            built = append_byte(built, CHAR_ESC);
            built = append_byte(built, CHAR_LBRACKET);
            built = append_byte(built, CHAR_FOUR);
            built = append_byte(built, CHAR_NINE);
            built = append_byte(built, CHAR_LOWER_M);
         end
         default: begin
            built.len = '0;
         end
      endcase
   end

   // next values of the registers
   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_beat) begin
         item_valid_in = 1'b1;
      end else if (load) begin
         item_valid_in = 1'b0;
      end

      text_in = text_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         text_in = built.text;
         cnt_in  = built.len;
      end else if (rsp_beat) begin
         text_in = {byte_type'(0), text_ff[SeqMax-1:1]};
         cnt_in  = cnt_ff - len_type'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff  <= req_bus.func;
         horiz_ff <= req_bus.horizontal_amount;
         row_ff   <= req_bus.row_number;
         color_ff <= req_bus.color_code;
      end
      text_ff <= text_in;
   end

endmodule

`default_nettype wire

// ===== sv/aesem_checker.sv =====
`default_nettype none

module aesem_checker import aesem_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   aesem_req_if.sink   req_bus,
   aesem_rsp_if.source rsp_bus
);

   // set while the next output byte opens a new sequence
   logic at_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         at_start_ff <= rsp_bus.last_byte;
      end
   end

   // nothing comes out straight after reset
   assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("output valid just after reset");

   // an empty block takes a command straight after reset
   assert property (@(posedge clock) reset |=> req_bus.ready)
      else $error("input not ready just after reset");

   // a stalled beat holds its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.tx_byte) && $stable(rsp_bus.last_byte))
      else $error("stalled output beat changed");

   // every sequence opens with escape
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && at_start_ff |-> rsp_bus.tx_byte == CHAR_ESC)
      else $error("sequence does not start with escape");

   // every sequence ends in a final letter
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last_byte |->
         (rsp_bus.tx_byte == CHAR_UPPER_J || rsp_bus.tx_byte == CHAR_UPPER_H ||
          rsp_bus.tx_byte == CHAR_UPPER_C || rsp_bus.tx_byte == CHAR_UPPER_D ||
          rsp_bus.tx_byte == CHAR_LOWER_M))
      else $error("final byte is not a command letter");

endmodule

bind ansi_escape_sequence_emitter_unit aesem_checker u_aesem_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

`default_nettype wire
